// ----- src/feed_message_decoder_defines.svh -----
// Assertion macros used by the checker file of the feed message decoder.
// No dependencies; every macro expects a clock and an active-low reset.
`ifndef FEED_MESSAGE_DECODER_DEFINES_SVH
`define FEED_MESSAGE_DECODER_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define FDEC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("feed message decoder check failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define FDEC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("feed message decoder sequence check failed");

`endif

// ----- src/fdec_pkg.sv -----
// Constants and the result record type of the feed message decoder.
// No dependencies; used by the top level and its checker.
`default_nettype none

package fdec_pkg;

  localparam logic [7:0] TYPE_ADD  = 8'h41;
  localparam logic [7:0] TYPE_EXEC = 8'h45;

  localparam logic [4:0] LEN_ADD    = 5'd28;
  localparam logic [4:0] LEN_EXEC   = 5'd17;
  localparam logic [4:0] LEN_CANCEL = 5'd13;

  localparam logic [4:0] POS_SEQ_LAST    = 5'd4;
  localparam logic [4:0] POS_ORDER_FIRST = 5'd5;
  localparam logic [4:0] POS_ORDER_LAST  = 5'd12;
  localparam logic [4:0] POS_SIDE        = 5'd13;
  localparam logic [4:0] POS_SYM_FIRST   = 5'd14;
  localparam logic [4:0] POS_EXEC_QLAST  = 5'd16;
  localparam logic [4:0] POS_PRICE_FIRST = 5'd20;
  localparam logic [4:0] POS_QTY_FIRST   = 5'd24;

  localparam logic [1:0] KIND_GAP    = 2'd0;
  localparam logic [1:0] KIND_ADD    = 2'd1;
  localparam logic [1:0] KIND_EXEC   = 2'd2;
  localparam logic [1:0] KIND_CANCEL = 2'd3;

  localparam int unsigned DATA_W = 248;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] sequence_res;
    logic [31:0] expected_sequence;
    logic [63:0] order_ref;
    logic [7:0]  side_code;
    logic [47:0] symbol_bytes;
    logic [31:0] price_cents;
    logic [31:0] quantity;
    logic        last_of_run;
  } result_t;

endpackage

`default_nettype wire

// ----- src/feed_message_decoder.sv -----
// Feed message decoder: assembles message fields byte by byte and queues
// gap and message records. Depends on fdec_pkg.
// Throughput: one byte per cycle unless a last byte waits. The records of a message appear
// in the cycle after its last byte is accepted; that byte waits only while
// records of the previous message remain in the two-entry result queue.
// Reset is asynchronous and active low and clears the control state and queue.
`default_nettype none

module feed_message_decoder (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [7:0]                  s_tdata,   // data_byte
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // sequence_res, expected_sequence, order_ref, side_code, symbol_bytes,
  // price_cents, quantity
  output logic [fdec_pkg::DATA_W-1:0]      m_tdata,
  output logic [1:0]                       m_tuser,   // kind
  output logic                             m_tlast    // last_of_run
);
  import fdec_pkg::*;

  logic [4:0]  pos_q, pos_d;
  logic [7:0]  type_q, type_d;
  logic [31:0] seq_q, seq_d;
  logic [63:0] order_q, order_d;
  logic [7:0]  side_q, side_d;
  logic [47:0] sym_q, sym_d;
  logic [31:0] price_q, price_d;
  logic [31:0] qty_q, qty_d;
  logic        seen_q, seen_d;
  logic [31:0] next_exp_q, next_exp_d;

  result_t     ent0_q, ent0_d, ent1_q, ent1_d;
  logic [1:0]  cnt_q, cnt_d;

  logic [4:0]  msg_len;
  logic        is_final;
  logic        in_fire, out_fire, gap;
  result_t     msg_rec, gap_rec;

  always_comb begin
    if (type_q == TYPE_ADD) begin
      msg_len = LEN_ADD;
    end else if (type_q == TYPE_EXEC) begin
      msg_len = LEN_EXEC;
    end else begin
      msg_len = LEN_CANCEL;
    end
  end

  // Position zero is never final since every message is at least 13 bytes.
  assign is_final = (pos_q != 5'd0) && (({1'b0, pos_q} + 6'd1) >= {1'b0, msg_len});
  assign s_tready = !is_final || (cnt_q == 2'd0);
  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;

  always_comb begin
    type_d  = type_q;
    seq_d   = seq_q;
    order_d = order_q;
    side_d  = side_q;
    sym_d   = sym_q;
    price_d = price_q;
    qty_d   = qty_q;
    if (pos_q == 5'd0) begin
      type_d = s_tdata;
    end else if (pos_q <= POS_SEQ_LAST) begin
      seq_d = {seq_q[23:0], s_tdata};
    end else if (pos_q inside {[POS_ORDER_FIRST:POS_ORDER_LAST]}) begin
      order_d = {order_q[55:0], s_tdata};
    end else if (type_q == TYPE_EXEC) begin
      if (pos_q <= POS_EXEC_QLAST) begin
        qty_d = {qty_q[23:0], s_tdata};
      end
    end else if (type_q == TYPE_ADD) begin
      if (pos_q == POS_SIDE) begin
        side_d = s_tdata;
      end else if (pos_q inside {[POS_SYM_FIRST:POS_PRICE_FIRST - 5'd1]}) begin
        sym_d = {sym_q[39:0], s_tdata};
      end else if (pos_q inside {[POS_PRICE_FIRST:POS_QTY_FIRST - 5'd1]}) begin
        price_d = {price_q[23:0], s_tdata};
      end else begin
        qty_d = {qty_q[23:0], s_tdata};
      end
    end
  end

  always_comb begin
    gap_rec                   = '0;
    gap_rec.kind              = KIND_GAP;
    gap_rec.sequence_res      = seq_d;
    gap_rec.expected_sequence = next_exp_q;

    msg_rec              = '0;
    msg_rec.sequence_res = seq_d;
    msg_rec.order_ref    = order_d;
    msg_rec.last_of_run  = 1'b1;
    if (type_q == TYPE_ADD) begin
      msg_rec.kind         = KIND_ADD;
      msg_rec.side_code    = side_d;
      msg_rec.symbol_bytes = sym_d;
      msg_rec.price_cents  = price_d;
      msg_rec.quantity     = qty_d;
    end else if (type_q == TYPE_EXEC) begin
      msg_rec.kind     = KIND_EXEC;
      msg_rec.quantity = qty_d;
    end else begin
      msg_rec.kind = KIND_CANCEL;
    end
  end

  assign gap = seen_q && (seq_d != next_exp_q);

  always_comb begin
    pos_d      = pos_q;
    seen_d     = seen_q;
    next_exp_d = next_exp_q;
    ent0_d     = ent0_q;
    ent1_d     = ent1_q;
    cnt_d      = cnt_q;
    if (out_fire) begin
      ent0_d = ent1_q;
      cnt_d  = cnt_q - 2'd1;
    end
    if (in_fire) begin
      if (is_final) begin
        pos_d      = 5'd0;
        seen_d     = 1'b1;
        next_exp_d = seq_d + 32'd1;
        // The queue is empty here, so no pop can happen in this cycle.
        if (gap) begin
          ent0_d = gap_rec;
          ent1_d = msg_rec;
          cnt_d  = 2'd2;
        end else begin
          ent0_d = msg_rec;
          cnt_d  = 2'd1;
        end
      end else begin
        pos_d = pos_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      type_q     <= '0;
      seen_q     <= 1'b0;
      next_exp_q <= '0;
      cnt_q      <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (in_fire) begin
        pos_q      <= pos_d;
        type_q     <= type_d;
        seen_q     <= seen_d;
        next_exp_q <= next_exp_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      seq_q   <= seq_d;
      order_q <= order_d;
      side_q  <= side_d;
      sym_q   <= sym_d;
      price_q <= price_d;
      qty_q   <= qty_d;
    end
    ent0_q <= ent0_d;
    ent1_q <= ent1_d;
  end

  assign m_tvalid = (cnt_q != 2'd0);
  assign m_tuser  = ent0_q.kind;
  assign m_tlast  = ent0_q.last_of_run;
  assign m_tdata  = {ent0_q.quantity, ent0_q.price_cents, ent0_q.symbol_bytes,
                     ent0_q.side_code, ent0_q.order_ref, ent0_q.expected_sequence,
                     ent0_q.sequence_res};

endmodule

`default_nettype wire

// ----- src/fdec_checker.sv -----
// Port-level checker for the feed message decoder and its bind statement.
// Depends on fdec_pkg and feed_message_decoder_defines.svh.
`default_nettype none
`include "feed_message_decoder_defines.svh"

module fdec_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        s_tvalid,
  input wire logic                        s_tready,
  input wire logic [7:0]                  s_tdata,
  input wire logic                        m_tvalid,
  input wire logic                        m_tready,
  input wire logic [fdec_pkg::DATA_W-1:0] m_tdata,
  input wire logic [1:0]                  m_tuser,
  input wire logic                        m_tlast
);
  import fdec_pkg::*;

  // A stalled request keeps its contents.
  `FDEC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

  // A gap record is never the final record of a message.
  `FDEC_ASSERT(a_gap_not_last, clk_i, rst_ni,
    !(m_tvalid && (m_tuser == KIND_GAP) && m_tlast))

  // The message record follows its gap record at once.
  `FDEC_ASSERT_NEXT(a_gap_then_msg, clk_i, rst_ni,
    m_tvalid && m_tready && (m_tuser == KIND_GAP),
    m_tvalid && (m_tuser != KIND_GAP) && m_tlast)

  // Only gap records carry an expected sequence number.
  `FDEC_ASSERT(a_exp_zero, clk_i, rst_ni,
    !(m_tvalid && (m_tuser != KIND_GAP) && (m_tdata[63:32] != 32'd0)))

  logic unused_in;
  assign unused_in = s_tvalid ^ s_tready ^ (^s_tdata);

endmodule

bind feed_message_decoder fdec_checker u_fdec_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire
